@@ sv/ffra_pkg.sv @@
// Package for the first-fit region allocator.
// Holds the codes, the register reset values and the shared types.
// Depends on nothing.
package ffra_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int OFF_W = 30;   // region start offset
  localparam int LEN_W = 31;   // lengths, sizes and span values
  localparam int OWN_W = 16;
  localparam int ADR_W = 31;
  localparam int ST_W  = 3;
  localparam int ENTRY_W = OFF_W + LEN_W + OWN_W;

  localparam logic [LEN_W-1:0] SPAN_LIMIT       = 31'd1073741824;
  localparam logic [LEN_W-1:0] HEAP_SIZE_RST    = 31'd524288000;
  localparam logic [LEN_W-1:0] MAX_REQUEST_RST  = 31'd52428800;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_LREG  = 2'd2;
  localparam logic [1:0] REQ_LGAP  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_SPACE  = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_NO_OWNER  = 3'd4;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;

  localparam logic [1:0] CFG_HEAP_BASE   = 2'd0;
  localparam logic [1:0] CFG_HEAP_SIZE   = 2'd1;
  localparam logic [1:0] CFG_MAX_REQUEST = 2'd2;

  typedef struct packed {
    logic [OWN_W-1:0] owner;
    logic [LEN_W-1:0] length;
    logic [OFF_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic [OFF_W-1:0] base;
    logic [LEN_W-1:0] heap_span;  // saturated heap size
    logic [LEN_W-1:0] max_req;    // saturated request limit
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] end_excl;
    logic [LEN_W-1:0] gap_len;
    logic             gap_pos;
    logic             fits;
  } scan_res_t;

endpackage

@@ sv/ffra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the region table; depends on nothing.
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/ffra_scan.sv @@
// Shared compare unit applied to one table entry per scan step.
// Gives the entry end and the gap to the previous end; uses ffra_pkg.
module ffra_scan
  import ffra_pkg::*;
(
  input  entry_t           entry,
  input  logic [LEN_W-1:0] prev_end,
  input  logic [LEN_W-1:0] size,
  output scan_res_t        res
);

  logic [LEN_W-1:0] start_w;
  logic [LEN_W-1:0] diff;

  assign start_w = {1'b0, entry.start};
  assign diff    = start_w - prev_end;

  always_comb begin
    res.end_excl = start_w + entry.length;
    res.gap_len  = diff;
    res.gap_pos  = start_w > prev_end;
    res.fits     = (start_w >= prev_end) && (diff >= size);
  end

endmodule

@@ sv/ffra_seq.sv @@
// Request sequencer: walks the region table in RAM one entry per step,
// inserts or removes by shifting, and drives the result register.
// Uses ffra_pkg, ffra_ram and ffra_scan.
module ffra_seq
  import ffra_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_req,
  input  logic [OWN_W-1:0] in_owner,
  input  logic [LEN_W-1:0] in_size,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  out_status,
  output logic [ADR_W-1:0] out_start,
  output logic [ADR_W-1:0] out_end,
  output logic [LEN_W-1:0] out_len,
  output logic [OWN_W-1:0] out_owner,
  output logic             out_last
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = LEN_W + IW;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CHECK  = 11'b00000000010,
    S_SC_RD  = 11'b00000000100,
    S_SC_USE = 11'b00000001000,
    S_FINISH = 11'b00000010000,
    S_UP_RD  = 11'b00000100000,
    S_UP_WR  = 11'b00001000000,
    S_INSERT = 11'b00010000000,
    S_DN_RD  = 11'b00100000000,
    S_DN_WR  = 11'b01000000000,
    S_FREE_O = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [OWN_W-1:0] own_r, own_nxt;
  logic [LEN_W-1:0] size_r, size_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    slot_r, slot_nxt;
  logic [LEN_W-1:0] prev_end_r, prev_end_nxt;
  logic [TW-1:0]    total_r, total_nxt;
  logic             found_r, found_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             gp_valid_r, gp_valid_nxt;
  logic [LEN_W-1:0] gp_off_r, gp_off_nxt;
  logic [LEN_W-1:0] gp_len_r, gp_len_nxt;
  logic             tail_done_r, tail_done_nxt;
  entry_t           fr_r, fr_nxt;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [ADR_W-1:0] out_start_r, out_end_r;
  logic [LEN_W-1:0] out_len_r;
  logic [OWN_W-1:0] out_owner_r;
  logic             out_last_r;

  // emit request towards the result register
  logic             emit;
  logic [ST_W-1:0]  e_status;
  logic [LEN_W-1:0] e_off, e_len;
  logic [OWN_W-1:0] e_own;
  logic             e_last;
  logic             slot_free;

  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  scan_res_t        sres;

  logic [TW:0]      need_total;
  logic [LEN_W:0]   tail_end;
  logic             tail_gap;

  ffra_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffra_scan u_scan (
    .entry    (ram_rdata),
    .prev_end (prev_end_r),
    .size     (size_r),
    .res      (sres)
  );

  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign need_total = {1'b0, total_r} + (TW+1)'(size_r);
  assign tail_end   = {1'b0, prev_end_r} + {1'b0, size_r};
  assign tail_gap   = cfg.heap_span > prev_end_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    own_nxt       = own_r;
    size_nxt      = size_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    slot_nxt      = slot_r;
    prev_end_nxt  = prev_end_r;
    total_nxt     = total_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    gp_valid_nxt  = gp_valid_r;
    gp_off_nxt    = gp_off_r;
    gp_len_nxt    = gp_len_r;
    tail_done_nxt = tail_done_r;
    fr_nxt        = fr_r;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_off     = '0;
    e_len     = '0;
    e_own     = '0;
    e_last    = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_r[IW-1:0];
    ram_raddr = idx_r[IW-1:0];
    ram_wdata = ram_rdata;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_req;
          own_nxt       = in_owner;
          size_nxt      = in_size;
          idx_nxt       = '0;
          prev_end_nxt  = '0;
          total_nxt     = '0;
          found_nxt     = 1'b0;
          gp_valid_nxt  = 1'b0;
          tail_done_nxt = 1'b0;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op_r == REQ_ALLOC && (size_r == '0 || size_r > cfg.max_req)) begin
          if (slot_free) begin
            emit      = 1'b1;
            e_status  = ST_BAD_SIZE;
            state_nxt = S_IDLE;
          end
        end else if (count_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SC_USE;
      end
      S_SC_USE: begin
        case (op_r)
          REQ_ALLOC: begin
            total_nxt = total_r + TW'(ram_rdata.length);
            if (!found_r && sres.fits) begin
              found_nxt = 1'b1;
              slot_nxt  = idx_r;
              pos_nxt   = prev_end_r;
            end
          end
          REQ_FREE: begin
            if (ram_rdata.owner == own_r) begin
              found_nxt = 1'b1;
              fr_nxt    = ram_rdata;
            end
          end
          REQ_LREG: begin
            emit     = slot_free;
            e_off    = {1'b0, ram_rdata.start};
            e_len    = ram_rdata.length;
            e_own    = ram_rdata.owner;
            e_last   = (idx_r + 1'b1) == count_r;
          end
          default: begin
            if (sres.gap_pos) begin
              emit       = slot_free && gp_valid_r;
              e_off      = gp_off_r;
              e_len      = gp_len_r;
              e_last     = 1'b0;
              if (slot_free || !gp_valid_r) begin
                gp_valid_nxt = 1'b1;
                gp_off_nxt   = prev_end_r;
                gp_len_nxt   = sres.gap_len;
              end
            end
          end
        endcase
        if (slot_free || op_r == REQ_ALLOC || op_r == REQ_FREE
            || (op_r == REQ_LGAP && !(sres.gap_pos && gp_valid_r))) begin
          prev_end_nxt = sres.end_excl;
          idx_nxt      = idx_r + 1'b1;
          if (op_r == REQ_FREE && ram_rdata.owner == own_r) begin
            state_nxt = S_DN_RD;
          end else if ((idx_r + 1'b1) == count_r) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SC_RD;
          end
        end
      end
      S_FINISH: begin
        case (op_r)
          REQ_ALLOC: begin
            if (need_total > (TW+1)'(cfg.heap_span)) begin
              if (slot_free) begin
                emit      = 1'b1;
                e_status  = ST_NO_SPACE;
                state_nxt = S_IDLE;
              end
            end else if (count_r >= DEPTH_C) begin
              if (slot_free) begin
                emit      = 1'b1;
                e_status  = ST_FULL;
                state_nxt = S_IDLE;
              end
            end else if (found_r) begin
              idx_nxt   = count_r;
              state_nxt = S_UP_RD;
            end else if (tail_end <= {1'b0, cfg.heap_span}) begin
              pos_nxt   = prev_end_r;
              slot_nxt  = count_r;
              idx_nxt   = count_r;
              state_nxt = S_UP_RD;
            end else if (slot_free) begin
              emit      = 1'b1;
              e_status  = ST_NO_SPACE;
              state_nxt = S_IDLE;
            end
          end
          REQ_FREE: begin
            if (slot_free) begin
              emit      = 1'b1;
              e_status  = ST_NO_OWNER;
              state_nxt = S_IDLE;
            end
          end
          REQ_LREG: begin
            if (count_r != '0) begin
              state_nxt = S_IDLE;
            end else if (slot_free) begin
              emit      = 1'b1;
              e_status  = ST_EMPTY;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (tail_gap && !tail_done_r) begin
              // Push out the held gap before taking the tail in its place.
              if (slot_free || !gp_valid_r) begin
                emit          = gp_valid_r;
                e_off         = gp_off_r;
                e_len         = gp_len_r;
                e_last        = 1'b0;
                gp_valid_nxt  = 1'b1;
                gp_off_nxt    = prev_end_r;
                gp_len_nxt    = cfg.heap_span - prev_end_r;
                tail_done_nxt = 1'b1;
              end
            end else if (slot_free) begin
              emit      = 1'b1;
              e_status  = gp_valid_r ? ST_OK : ST_EMPTY;
              e_off     = gp_valid_r ? gp_off_r : '0;
              e_len     = gp_valid_r ? gp_len_r : '0;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_UP_RD: begin
        if (idx_r == slot_r) begin
          state_nxt = S_INSERT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IW'(idx_r - 1'b1);
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_UP_RD;
      end
      S_INSERT: begin
        ram_waddr = slot_r[IW-1:0];
        ram_wdata.start  = pos_r[OFF_W-1:0];
        ram_wdata.length = size_r;
        ram_wdata.owner  = own_r;
        if (slot_free) begin
          ram_we    = 1'b1;
          emit      = 1'b1;
          e_off     = pos_r;
          e_len     = size_r;
          e_own     = own_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DN_RD: begin
        if (idx_r == count_r) begin
          state_nxt = S_FREE_O;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(idx_r - 1'b1);
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_DN_RD;
      end
      S_FREE_O: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_off     = {1'b0, fr_r.start};
          e_len     = fr_r.length;
          e_own     = fr_r.owner;
          count_nxt = count_r - 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    own_r       <= own_nxt;
    size_r      <= size_nxt;
    idx_r       <= idx_nxt;
    slot_r      <= slot_nxt;
    prev_end_r  <= prev_end_nxt;
    total_r     <= total_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    gp_valid_r  <= gp_valid_nxt;
    gp_off_r    <= gp_off_nxt;
    gp_len_r    <= gp_len_nxt;
    tail_done_r <= tail_done_nxt;
    fr_r        <= fr_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_len_r    <= e_len;
      out_owner_r  <= e_own;
      out_last_r   <= e_last;
      if (e_len == '0) begin
        out_start_r <= '0;
        out_end_r   <= '0;
      end else begin
        out_start_r <= ADR_W'({2'b0, cfg.base} + {1'b0, e_off});
        out_end_r   <= ADR_W'({2'b0, cfg.base} + {1'b0, e_off} + {1'b0, e_len} - 32'd1);
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_start  = out_start_r;
  assign out_end    = out_end_r;
  assign out_len    = out_len_r;
  assign out_owner  = out_owner_r;
  assign out_last   = out_last_r;

endmodule

@@ sv/first_fit_region_allocator_top.sv @@
// Top level of the first-fit region allocator.
// Holds the configuration registers and the stream ports; uses ffra_pkg and ffra_seq.
//
// The block manages a table of up to TABLE_DEPTH regions of a heap, sorted by
// start offset. A request arrives as one transfer on the in_ stream: allocate,
// free by owner, list regions or list free gaps. Each request gives one or more
// result transfers on the out_ stream, the final one with out_tlast high.
// Configuration registers (heap base, heap size, largest request) are written
// on the cfg_ channel, which is always ready; they should only be changed
// while no request is in progress.
// One request is handled at a time and in_tready is low meanwhile. The
// sequencer reads the region table RAM one entry at a time, each in a read
// state and a use state; a placed allocation then moves the entries above its
// slot up one place, and a free moves the entries above the freed one down.
// List requests give their results during the scan, which waits whenever the
// receiver holds off.
// The result sits in an output register; while the receiver holds out_tready
// low the sequencer waits at its next result, and no result is lost.
// Reset clears the region count, so the table reads as empty, and returns the
// registers to their reset values; the table RAM itself needs no clearing.
module first_fit_region_allocator_top
  import ffra_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata: req_type[1:0], owner_id[17:2], request_size[48:18], zero fill
  input  logic [55:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata: status[2:0], first byte address[33:3], last byte address[64:34],
  // block_length[95:65], region_owner[111:96]
  output logic [111:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  logic [OFF_W-1:0] heap_base_r;
  logic [LEN_W-1:0] heap_size_r;
  logic [LEN_W-1:0] max_request_r;
  cfg_t             cfg;

  logic [ST_W-1:0]  o_status;
  logic [ADR_W-1:0] o_start, o_end;
  logic [LEN_W-1:0] o_len;
  logic [OWN_W-1:0] o_owner;

  assign cfg_ready = 1'b1;

  // Register writes land on the cycle of the transfer; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r   <= '0;
      heap_size_r   <= HEAP_SIZE_RST;
      max_request_r <= MAX_REQUEST_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEAP_BASE:   heap_base_r   <= cfg_data[OFF_W-1:0];
        CFG_HEAP_SIZE:   heap_size_r   <= cfg_data;
        CFG_MAX_REQUEST: max_request_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sizes above the largest span act as that span.
  always_comb begin
    cfg.base      = heap_base_r;
    cfg.heap_span = (heap_size_r > SPAN_LIMIT) ? SPAN_LIMIT : heap_size_r;
    cfg.max_req   = (max_request_r > SPAN_LIMIT) ? SPAN_LIMIT : max_request_r;
  end

  ffra_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_req     (in_tdata[1:0]),
    .in_owner   (in_tdata[17:2]),
    .in_size    (in_tdata[48:18]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (o_status),
    .out_start  (o_start),
    .out_end    (o_end),
    .out_len    (o_len),
    .out_owner  (o_owner),
    .out_last   (out_tlast)
  );

  assign out_tdata = {o_owner, o_len, o_end, o_start, o_status};

endmodule

@@ sv/ffra_checker.sv @@
// Port-level checker for the first-fit region allocator, with its bind.
// Uses ffra_pkg; attaches to first_fit_region_allocator_top.
module ffra_checker
  import ffra_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic         out_tlast
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // The block is busy in the cycle after it accepts a request.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // Reset leaves no result on offer.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // A rejection or an empty answer is a single, final, all-zero result.
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tlast && out_tdata[111:3] == '0)
    else $error("rejection not final or not cleared");

endmodule

bind first_fit_region_allocator_top ffra_checker u_ffra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ verif/ffra_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the first-fit region allocator: watches the cfg_, in_ and
// out_ channels, keeps its own copy of the region table and checks every result.
// Depends on ffra_pkg.
module ffra_result_checker
  import ffra_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [55:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [111:0] out_tdata,
  input  logic         out_tlast,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [ADR_W-1:0] first_addr;
    logic [ADR_W-1:0] last_addr;
    logic [LEN_W-1:0] length;
    logic [OWN_W-1:0] owner;
    logic             tlast;
  } alloc_result_t;

  alloc_result_t expected_results[$];

  logic [OFF_W-1:0] cfg_base;
  logic [LEN_W-1:0] cfg_heap_size;
  logic [LEN_W-1:0] cfg_max_req;

  logic [OFF_W-1:0] tbl_start [TABLE_DEPTH_DEF];
  logic [LEN_W-1:0] tbl_length[TABLE_DEPTH_DEF];
  logic [OWN_W-1:0] tbl_owner [TABLE_DEPTH_DEF];
  int               tbl_count;

  function automatic longint unsigned saturate_span(logic [LEN_W-1:0] v);
    return (v > SPAN_LIMIT) ? longint'(SPAN_LIMIT) : longint'(v);
  endfunction

  function automatic longint unsigned region_end(int i);
    return longint'(tbl_start[i]) + longint'(tbl_length[i]);
  endfunction

  // A zero length means a rejected or empty answer, which reports no addresses.
  function automatic void push_result(logic [ST_W-1:0] st, longint unsigned off,
                                      longint unsigned len, logic [OWN_W-1:0] own,
                                      logic lst);
    alloc_result_t r;
    longint unsigned first_byte;
    first_byte = longint'(cfg_base) + off;
    r.status = st;
    r.first_addr = (len == 0) ? '0 : first_byte[ADR_W-1:0];
    first_byte = first_byte + len - 1;
    r.last_addr = (len == 0) ? '0 : first_byte[ADR_W-1:0];
    r.length = len[LEN_W-1:0];
    r.owner = own;
    r.tlast = lst;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void predict_alloc(logic [OWN_W-1:0] own, logic [LEN_W-1:0] req_size);
    longint unsigned span, total, pos, sz, e;
    int slot;
    bit found;
    span = saturate_span(cfg_heap_size);
    sz = longint'(req_size);
    total = 0;
    pos = 0;
    found = 0;
    if (sz == 0 || sz > saturate_span(cfg_max_req)) begin
      push_result(ST_BAD_SIZE, 0, 0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < tbl_count; i++) total += tbl_length[i];
    if (total + sz > span) begin
      push_result(ST_NO_SPACE, 0, 0, '0, 1'b1);
      return;
    end
    if (tbl_count >= TABLE_DEPTH_DEF) begin
      push_result(ST_FULL, 0, 0, '0, 1'b1);
      return;
    end
    if (tbl_count == 0 || longint'(tbl_start[0]) >= sz) begin
      slot = 0;
      found = 1;
    end else begin
      slot = tbl_count;
      for (int i = 1; i < tbl_count && !found; i++) begin
        e = region_end(i - 1);
        if (longint'(tbl_start[i]) >= e && longint'(tbl_start[i]) - e >= sz) begin
          pos = e;
          slot = i;
          found = 1;
        end
      end
      if (!found) begin
        pos = region_end(tbl_count - 1);
        if (pos + sz <= span) found = 1;
      end
    end
    if (!found) begin
      push_result(ST_NO_SPACE, 0, 0, '0, 1'b1);
      return;
    end
    for (int i = tbl_count; i > slot; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_length[i] = tbl_length[i-1];
      tbl_owner[i] = tbl_owner[i-1];
    end
    tbl_start[slot] = pos[OFF_W-1:0];
    tbl_length[slot] = req_size;
    tbl_owner[slot] = own;
    tbl_count++;
    push_result(ST_OK, pos, sz, own, 1'b1);
  endfunction

  function automatic void predict_free(logic [OWN_W-1:0] own);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_owner[i] == own) begin
        push_result(ST_OK, tbl_start[i], tbl_length[i], tbl_owner[i], 1'b1);
        for (int j = i; j + 1 < tbl_count; j++) begin
          tbl_start[j] = tbl_start[j+1];
          tbl_length[j] = tbl_length[j+1];
          tbl_owner[j] = tbl_owner[j+1];
        end
        tbl_count--;
        return;
      end
    end
    push_result(ST_NO_OWNER, 0, 0, '0, 1'b1);
  endfunction

  function automatic void predict_region_list();
    if (tbl_count == 0) begin
      push_result(ST_EMPTY, 0, 0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < tbl_count; i++)
      push_result(ST_OK, tbl_start[i], tbl_length[i], tbl_owner[i], i + 1 == tbl_count);
  endfunction

  // Gaps: before the first region, between neighbours, and the tail up to the
  // heap size, the tail only where the last region ends below it.
  function automatic void predict_gap_list();
    longint unsigned gap_at [TABLE_DEPTH_DEF+1];
    longint unsigned gap_len[TABLE_DEPTH_DEF+1];
    int n;
    longint unsigned span, e;
    n = 0;
    span = saturate_span(cfg_heap_size);
    if (tbl_count == 0) begin
      if (span > 0) begin
        gap_at[n] = 0;
        gap_len[n] = span;
        n++;
      end
    end else begin
      if (tbl_start[0] > 0) begin
        gap_at[n] = 0;
        gap_len[n] = longint'(tbl_start[0]);
        n++;
      end
      for (int i = 1; i < tbl_count; i++) begin
        e = region_end(i - 1);
        if (longint'(tbl_start[i]) > e) begin
          gap_at[n] = e;
          gap_len[n] = longint'(tbl_start[i]) - e;
          n++;
        end
      end
      e = region_end(tbl_count - 1);
      if (span > e) begin
        gap_at[n] = e;
        gap_len[n] = span - e;
        n++;
      end
    end
    if (n == 0) begin
      push_result(ST_EMPTY, 0, 0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++)
      push_result(ST_OK, gap_at[i], gap_len[i], '0, i + 1 == n);
  endfunction

  task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst_n) begin
      cfg_base = '0;
      cfg_heap_size = HEAP_SIZE_RST;
      cfg_max_req = MAX_REQUEST_RST;
      tbl_count = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // Results are checked first: a result in this cycle cannot belong to a
      // request accepted in the same cycle.
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, actual status %0d", $time,
                   out_tdata[2:0]);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          compare_field("status", exp_r.status, out_tdata[2:0]);
          compare_field("first_addr", exp_r.first_addr, out_tdata[33:3]);
          compare_field("last_addr", exp_r.last_addr, out_tdata[64:34]);
          compare_field("block_length", exp_r.length, out_tdata[95:65]);
          compare_field("region_owner", exp_r.owner, out_tdata[111:96]);
          compare_field("last", exp_r.tlast, out_tlast);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEAP_BASE:   cfg_base = cfg_data[OFF_W-1:0];
          CFG_HEAP_SIZE:   cfg_heap_size = cfg_data;
          CFG_MAX_REQUEST: cfg_max_req = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        case (in_tdata[1:0])
          REQ_ALLOC: predict_alloc(in_tdata[17:2], in_tdata[48:18]);
          REQ_FREE:  predict_free(in_tdata[17:2]);
          REQ_LREG:  predict_region_list();
          default:   predict_gap_list();
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ verif/first_fit_region_allocator_top_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the first-fit region allocator: clock, reset, stimulus,
// configuration phases and the verdict. Depends on ffra_pkg, the block and
// ffra_result_checker, which predicts and compares the results.
module first_fit_region_allocator_top_test;
  import ffra_pkg::*;

  // Settle time that covers the slowest request, so that it can finish.
  localparam int SETTLE_CYCLES = 4 * TABLE_DEPTH_DEF + 20;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 400;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [55:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [30:0]  cfg_data;

  int fail_count;
  int pending;

  // Stimulus controls shared with the receiver process.
  bit idle_en;
  int hold_requests;
  int hold_served;

  // Heap size currently programmed, used to scale random request sizes.
  longint unsigned heap_now;

  first_fit_region_allocator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ffra_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: a run that never drains ends here as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver. Each falling edge makes exactly one decision about out_tready:
  // a long hold-off when the stimulus asks for one, otherwise random stall
  // bursts while idling is enabled.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    hold_served = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one request and returns at the rising edge that completes the
  // transfer. in_tvalid stays high into the next request unless a gap is taken.
  task automatic send_request(logic [1:0] kind, logic [15:0] owner, logic [30:0] req_size);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tdata <= {7'd0, req_size, owner, kind};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops sending and waits until every expected result has arrived and the
  // block has had time to finish any request still under way.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only from a drained, idle block.
  task automatic write_register(logic [1:0] idx, logic [30:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_heap(logic [30:0] base, logic [30:0] heap, logic [30:0] max_req);
    write_register(CFG_HEAP_BASE, base);
    write_register(CFG_HEAP_SIZE, heap);
    write_register(CFG_MAX_REQUEST, max_req);
    heap_now = (heap > SPAN_LIMIT) ? SPAN_LIMIT : heap;
  endtask

  // Random traffic: mostly allocate and free from a small pool of owners, so
  // the table fills, fragments and empties again; now and then a stray owner,
  // a zero size or an oversized request, and list requests throughout.
  task automatic random_traffic(int count, bit with_hold);
    int pick;
    logic [15:0] owner;
    logic [30:0] req_size;
    longint unsigned top_size;
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 2) hold_requests++;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       owner = 16'($urandom_range(0, 65535));
        1:       owner = 16'hFFFF;
        default: owner = 16'($urandom_range(0, 5));
      endcase
      top_size = heap_now / 5 + 1;
      case ($urandom_range(0, 19))
        0:       req_size = 31'd0;
        1:       req_size = 31'($urandom_range(0, 1073741824));
        2:       req_size = 31'd1;
        default: req_size = 31'($urandom_range(1, int'(top_size)));
      endcase
      if (pick < 48)      send_request(REQ_ALLOC, owner, req_size);
      else if (pick < 78) send_request(REQ_FREE, owner, req_size);
      else if (pick < 89) send_request(REQ_LREG, owner, req_size);
      else                send_request(REQ_LGAP, owner, req_size);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HEAP_BASE;
    cfg_data = '0;
    idle_en = 1'b1;
    hold_requests = 0;
    heap_now = HEAP_SIZE_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset values: empty lists, free with no owner, size
    // limits, a full heap budget and its rejection.
    send_request(REQ_LGAP, 16'h0000, 31'd0);
    send_request(REQ_LREG, 16'hFFFF, 31'h7FFFFFFF);
    send_request(REQ_FREE, 16'h0000, 31'd0);
    send_request(REQ_ALLOC, 16'h0000, 31'd0);
    send_request(REQ_ALLOC, 16'h0001, 31'd52428801);
    send_request(REQ_ALLOC, 16'h0001, 31'd1073741824);
    send_request(REQ_ALLOC, 16'h0001, 31'd1073741823);
    for (int i = 0; i < 10; i++) send_request(REQ_ALLOC, 16'hFFFF, 31'd52428800);
    send_request(REQ_ALLOC, 16'h0002, 31'd1);
    send_request(REQ_FREE, 16'hFFFF, 31'd0);
    send_request(REQ_ALLOC, 16'h0002, 31'd7);
    send_request(REQ_LGAP, 16'h0000, 31'd0);
    drain();

    // The heap shrinks below the regions it holds: they stay, and the tail
    // gap disappears.
    program_heap(31'h3FFFFFFF, 31'd1000, 31'd1);
    send_request(REQ_LREG, 16'h0000, 31'd0);
    send_request(REQ_LGAP, 16'h0000, 31'd0);
    send_request(REQ_ALLOC, 16'h0003, 31'd1);
    for (int i = 0; i < 10; i++) send_request(REQ_FREE, 16'hFFFF, 31'd0);
    send_request(REQ_FREE, 16'h0002, 31'd0);
    drain();

    // Oversized registers act as saturated at 2^30.
    program_heap(31'h3FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    send_request(REQ_ALLOC, 16'h0004, 31'd1073741824);
    send_request(REQ_ALLOC, 16'h0005, 31'd1);
    send_request(REQ_LGAP, 16'h0000, 31'd0);
    send_request(REQ_FREE, 16'h0004, 31'd0);
    drain();

    // Random phases at several settings. A small heap fills the table often,
    // the receiver holds off once in the first phase, and the smallest heap
    // gives the tightest extremes.
    program_heap(31'($urandom_range(0, 1073741823)), 31'd4096, 31'd1500);
    random_traffic(130, 1'b1);
    drain();

    program_heap(31'd0, 31'd1, 31'd1);
    random_traffic(40, 1'b0);
    drain();

    program_heap(31'($urandom_range(0, 1073741823)), 31'h7FFFFFFF, 31'd300000000);
    random_traffic(120, 1'b0);
    drain();

    // Final phase without any idling on either side.
    program_heap(31'h3FFFFFFF, 31'd60000, 31'd60000);
    idle_en = 1'b0;
    random_traffic(130, 1'b0);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ffra_pkg.sv
sv/ffra_ram.sv
sv/ffra_scan.sv
sv/ffra_seq.sv
sv/first_fit_region_allocator_top.sv
sv/ffra_checker.sv
verif/ffra_result_checker.sv
verif/first_fit_region_allocator_top_test.sv
